// ===== rtl/core/nlt_pkg.sv =====
`timescale 1ns / 1ps
// shared types and constants of the neighbor liveness tracker
// no dependencies

package nlt_pkg;

  // number of router interfaces with a neighbor slot
  localparam int PORTS     = 4;
  localparam int SLOT_AW   = (PORTS > 1) ? $clog2(PORTS) : 1;
  localparam int NUM_MASKS = 4;
  localparam int PORT_W    = 2;
  localparam int CFG_IDX_W = 3;

  typedef enum logic [2:0] {
    EV_SEND_HELLO = 3'd0,
    EV_REFRESH    = 3'd1,
    EV_NEW_NBR    = 3'd2,
    EV_MASK_DROP  = 3'd3,
    EV_TIMEOUT    = 3'd4,
    EV_FLOOD_ALL  = 3'd5
  } event_t;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_MASK0 = 3'd0,
    CFG_MASK1 = 3'd1,
    CFG_MASK2 = 3'd2,
    CFG_MASK3 = 3'd3,
    CFG_DEAD  = 3'd4,
    CFG_LSU   = 3'd5
  } cfg_idx_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_HELLO,
    ST_SCAN,
    ST_FLOOD,
    ST_FINISH
  } state_t;

  typedef struct packed {
    logic [NUM_MASKS-1:0][31:0] mask;
    logic [15:0]                dead;
    logic [15:0]                lsu_period;
  } cfg_t;

  typedef struct packed {
    logic [31:0] rid;
    logic [31:0] addr;
    logic [31:0] seen;
  } slot_t;

  typedef struct packed {
    event_t            ev;
    logic [PORT_W-1:0] port;
    logic [31:0]       rid;
    logic [31:0]       addr;
  } res_t;

endpackage

// ===== rtl/core/nlt_ram.sv =====
`timescale 1ns / 1ps
// generic single write port ram with one registered read port
// no dependencies

module nlt_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 4
) (
  input  logic                                    clk,
  input  logic                                    we,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
  input  logic [WIDTH-1:0]                        wdata,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
  output logic [WIDTH-1:0]                        rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

// ===== rtl/core/nlt_cfg.sv =====
`timescale 1ns / 1ps
// configuration register file: interface masks, dead interval, flood period
// depends on nlt_pkg

module nlt_cfg import nlt_pkg::*; (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 cfg_valid,
  output logic                 cfg_ready,
  input  logic [CFG_IDX_W-1:0] cfg_index,
  input  logic [31:0]          cfg_data,
  output cfg_t                 cfg
);

  cfg_t cfg_r;

  assign cfg_ready = 1'b1;
  assign cfg       = cfg_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.mask       <= '0;
      cfg_r.dead       <= 16'd15;
      cfg_r.lsu_period <= 16'd30;
    end else if (cfg_valid) begin
      unique case (cfg_index)
        CFG_MASK0: cfg_r.mask[0]    <= cfg_data;
        CFG_MASK1: cfg_r.mask[1]    <= cfg_data;
        CFG_MASK2: cfg_r.mask[2]    <= cfg_data;
        CFG_MASK3: cfg_r.mask[3]    <= cfg_data;
        CFG_DEAD:  cfg_r.dead       <= cfg_data[15:0];
        CFG_LSU:   cfg_r.lsu_period <= cfg_data[15:0];
        default: ;
      endcase
    end
  end

endmodule

// ===== rtl/core/neighbor_liveness_tracker.sv =====
`timescale 1ns / 1ps
// top level of the neighbor liveness tracker: sequencer, slot ram, output word
// depends on nlt_pkg, nlt_ram, nlt_cfg

// Keeps one neighbor slot (router id, address, last seen time) per interface in a
// small ram and handles one input word at a time. A hello word reads its slot,
// then compares and, when the mask matches, writes the slot back, then hands its
// result to the output register. A tick word scans the slots through the single
// ram read port, one slot per cycle while no removal waits on a busy output
// register, then checks for a flood and hands on its last result. Every word takes
// longer while the output side stalls. Results leave through an output register, so
// the next input word is taken while the last result of the previous one still waits.
// Slot state is cleared at reset through per slot valid bits, with no clearing pass.
// Configuration writes are always ready and are registered before they take effect.

module neighbor_liveness_tracker import nlt_pkg::*; (
  input  logic                 clk,
  input  logic                 rst_n,
  // input words
  input  logic                 in_valid,
  output logic                 in_ready,
  input  logic                 in_mode,
  input  logic [PORT_W-1:0]    in_port_index,
  input  logic [31:0]          in_sender_rid,
  input  logic [31:0]          in_sender_addr,
  input  logic [31:0]          in_sender_mask,
  input  logic [31:0]          in_now_seconds,
  // result words
  output logic                 out_valid,
  input  logic                 out_ready,
  output logic [2:0]           out_event_res,
  output logic [PORT_W-1:0]    out_port_out,
  output logic [31:0]          out_neighbor_rid,
  output logic [31:0]          out_neighbor_addr,
  output logic                 out_last,
  // configuration writes
  input  logic                 cfg_valid,
  output logic                 cfg_ready,
  input  logic [CFG_IDX_W-1:0] cfg_index,
  input  logic [31:0]          cfg_data
);

  cfg_t cfg;

  nlt_cfg u_cfg (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .cfg       (cfg)
  );

  // sequencer state
  state_t              state_r, state_nxt;
  logic [SLOT_AW-1:0]  idx_r, idx_nxt;        // slot being worked on
  logic [PORTS-1:0]    valid_r;               // slot holds written data
  logic                changed_r;             // a neighbor was removed this tick
  logic [31:0]         last_flood_r;

  // latched input word
  logic [PORT_W-1:0]   port_r;
  logic [31:0]         rid_r;
  logic [31:0]         addr_r;
  logic [31:0]         smask_r;
  logic [31:0]         now_r;

  // one result held back until we know whether it is the last one
  res_t                pend_r;
  res_t                pend_new;
  logic                pend_ld;

  // output register
  res_t                out_r;
  logic                out_last_r;
  logic                out_valid_r;
  logic                push;
  logic                push_last;
  logic                can_push;

  // slot ram
  logic [SLOT_AW-1:0]  rd_addr;
  slot_t               rd_data;
  slot_t               slot_q;
  logic                ram_we;
  slot_t               ram_wdata;

  // control strobes
  logic                accept;
  logic                tick_start;
  logic                val_set;
  logic                val_clr;
  logic                chg_set;
  logic                flood_ld;

  // derived checks
  logic                expired;
  logic                periodic_due;
  logic                mask_ok;
  logic                rid_match;
  logic [31:0]         silence;
  logic [31:0]         since_flood;

  nlt_ram #(
    .WIDTH ($bits(slot_t)),
    .DEPTH (PORTS)
  ) u_slot_ram (
    .clk   (clk),
    .we    (ram_we),
    .waddr (idx_r),
    .wdata (ram_wdata),
    .raddr (rd_addr),
    .rdata (rd_data)
  );

  // a slot never written since reset reads as empty
  assign slot_q       = valid_r[idx_r] ? rd_data : '0;

  assign silence      = now_r - slot_q.seen;
  assign since_flood  = now_r - last_flood_r;
  assign expired      = (slot_q.rid != 32'd0) && (silence > {16'd0, cfg.dead});
  assign periodic_due = since_flood >= {16'd0, cfg.lsu_period};
  assign mask_ok      = smask_r == cfg.mask[port_r];
  assign rid_match    = (slot_q.rid != 32'd0) && (slot_q.rid == rid_r);

  assign ram_wdata    = '{rid: rid_r, addr: addr_r, seen: now_r};
  assign can_push     = !out_valid_r || out_ready;
  assign accept       = in_valid && in_ready;

  // next state and control
  always_comb begin
    state_nxt  = state_r;
    idx_nxt    = idx_r;
    rd_addr    = idx_r;
    in_ready   = 1'b0;
    ram_we     = 1'b0;
    pend_ld    = 1'b0;
    pend_new   = '{ev: EV_SEND_HELLO, port: '0, rid: '0, addr: '0};
    push       = 1'b0;
    push_last  = 1'b0;
    val_set    = 1'b0;
    val_clr    = 1'b0;
    chg_set    = 1'b0;
    flood_ld   = 1'b0;
    tick_start = 1'b0;
    unique case (state_r)
      ST_IDLE: begin
        in_ready = 1'b1;
        rd_addr  = in_mode ? '0 : in_port_index[SLOT_AW-1:0];
        if (in_valid) begin
          idx_nxt = rd_addr;
          if (in_mode) begin
            // hello request word goes first on every tick
            tick_start = 1'b1;
            pend_ld    = 1'b1;
            state_nxt  = ST_SCAN;
          end else if (32'(in_port_index) < 32'(PORTS)) begin
            state_nxt = ST_HELLO;
          end
        end
      end
      ST_HELLO: begin
        pend_ld = 1'b1;
        if (!mask_ok) begin
          pend_new = '{ev: EV_MASK_DROP, port: port_r, rid: rid_r, addr: addr_r};
        end else begin
          ram_we   = 1'b1;
          val_set  = 1'b1;
          pend_new = '{ev: rid_match ? EV_REFRESH : EV_NEW_NBR, port: port_r,
                       rid: rid_r, addr: addr_r};
        end
        state_nxt = ST_FINISH;
      end
      ST_SCAN: begin
        // stall on a removal while the output register is busy, holding the read
        if (!expired || can_push) begin
          if (expired) begin
            push     = 1'b1;
            pend_ld  = 1'b1;
            pend_new = '{ev: EV_TIMEOUT, port: PORT_W'(idx_r), rid: slot_q.rid,
                         addr: slot_q.addr};
            val_clr  = 1'b1;
            chg_set  = 1'b1;
          end
          if (idx_r == SLOT_AW'(PORTS - 1)) begin
            state_nxt = ST_FLOOD;
          end else begin
            idx_nxt = idx_r + 1'b1;
            rd_addr = idx_r + 1'b1;
          end
        end
      end
      ST_FLOOD: begin
        if (changed_r || periodic_due) begin
          if (can_push) begin
            push      = 1'b1;
            pend_ld   = 1'b1;
            pend_new  = '{ev: EV_FLOOD_ALL, port: '0, rid: '0, addr: '0};
            flood_ld  = 1'b1;
            state_nxt = ST_FINISH;
          end
        end else begin
          state_nxt = ST_FINISH;
        end
      end
      ST_FINISH: begin
        if (can_push) begin
          push      = 1'b1;
          push_last = 1'b1;
          state_nxt = ST_IDLE;
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  // control registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= ST_IDLE;
      valid_r      <= '0;
      changed_r    <= 1'b0;
      last_flood_r <= '0;
      out_valid_r  <= 1'b0;
    end else begin
      state_r <= state_nxt;
      if (val_set) begin
        valid_r[idx_r] <= 1'b1;
      end else if (val_clr) begin
        // a removed neighbor is unobservable, so dropping the valid bit clears it
        valid_r[idx_r] <= 1'b0;
      end
      if (tick_start) begin
        changed_r <= 1'b0;
      end else if (chg_set) begin
        changed_r <= 1'b1;
      end
      if (flood_ld) begin
        last_flood_r <= now_r;
      end
      if (push) begin
        out_valid_r <= 1'b1;
      end else if (out_ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  // payload registers
  always_ff @(posedge clk) begin
    idx_r <= idx_nxt;
    if (accept) begin
      port_r  <= in_port_index;
      rid_r   <= in_sender_rid;
      addr_r  <= in_sender_addr;
      smask_r <= in_sender_mask;
      now_r   <= in_now_seconds;
    end
    if (push) begin
      out_r      <= pend_r;
      out_last_r <= push_last;
    end
    if (pend_ld) begin
      pend_r <= pend_new;
    end
  end

  assign out_valid         = out_valid_r;
  assign out_event_res     = out_r.ev;
  assign out_port_out      = out_r.port;
  assign out_neighbor_rid  = out_r.rid;
  assign out_neighbor_addr = out_r.addr;
  assign out_last          = out_last_r;

endmodule

// ===== test/tb_neighbor_liveness_tracker.sv =====
`timescale 1ns / 1ps
// self-checking bench for neighbor_liveness_tracker: hello and tick words against a
// slot/timer predictor, with random stalls on both sides and config between phases
// depends on nlt_pkg and the neighbor_liveness_tracker rtl

module tb_neighbor_liveness_tracker;
  import nlt_pkg::*;

  localparam int MAX_CYCLES = 400000;

  // one input word as the sender holds it
  typedef struct packed {
    logic              mode;
    logic [PORT_W-1:0] port;
    logic [31:0]       rid;
    logic [31:0]       addr;
    logic [31:0]       mask;
    logic [31:0]       now;
  } hello_word_t;

  // one result word as the block should produce it
  typedef struct packed {
    event_t            ev;
    logic [PORT_W-1:0] port;
    logic [31:0]       rid;
    logic [31:0]       addr;
    logic              last;
  } nbr_event_t;

  logic                 clk = 1'b0;
  logic                 rst_n = 1'b0;
  logic                 in_valid = 1'b0;
  logic                 in_ready;
  logic                 in_mode = 1'b0;
  logic [PORT_W-1:0]    in_port_index = '0;
  logic [31:0]          in_sender_rid = '0;
  logic [31:0]          in_sender_addr = '0;
  logic [31:0]          in_sender_mask = '0;
  logic [31:0]          in_now_seconds = '0;
  logic                 out_valid;
  logic                 out_ready = 1'b0;
  logic [2:0]           out_event_res;
  logic [PORT_W-1:0]    out_port_out;
  logic [31:0]          out_neighbor_rid;
  logic [31:0]          out_neighbor_addr;
  logic                 out_last;
  logic                 cfg_valid = 1'b0;
  logic                 cfg_ready;
  logic [CFG_IDX_W-1:0] cfg_index = '0;
  logic [31:0]          cfg_data = '0;

  neighbor_liveness_tracker dut (
    .clk              (clk),
    .rst_n            (rst_n),
    .in_valid         (in_valid),
    .in_ready         (in_ready),
    .in_mode          (in_mode),
    .in_port_index    (in_port_index),
    .in_sender_rid    (in_sender_rid),
    .in_sender_addr   (in_sender_addr),
    .in_sender_mask   (in_sender_mask),
    .in_now_seconds   (in_now_seconds),
    .out_valid        (out_valid),
    .out_ready        (out_ready),
    .out_event_res    (out_event_res),
    .out_port_out     (out_port_out),
    .out_neighbor_rid (out_neighbor_rid),
    .out_neighbor_addr(out_neighbor_addr),
    .out_last         (out_last),
    .cfg_valid        (cfg_valid),
    .cfg_ready        (cfg_ready),
    .cfg_index        (cfg_index),
    .cfg_data         (cfg_data)
  );

  always #5 clk = ~clk;

  // words waiting to be sent and results waiting to come back
  hello_word_t pending_words[$];
  nbr_event_t  expected_events[$];

  // predictor copy of the configuration
  logic [31:0] iface_mask[PORTS];
  logic [15:0] dead_limit;
  logic [15:0] lsu_period;

  // predictor copy of the neighbor table and flood timer
  logic [31:0] nbr_rid[PORTS];
  logic [31:0] nbr_addr[PORTS];
  logic [31:0] nbr_seen[PORTS];
  logic [31:0] flood_stamp;

  int          mismatches = 0;
  int          cycles = 0;
  bit          quiet = 1'b0;     // no idling on either side while set
  logic [31:0] sim_clock = 32'd1000;

  // driver and monitor bookkeeping
  hello_word_t cur_word = '0;
  bit          busy = 1'b0;
  int          gap_left = 0;
  int          stall_left = 0;
  nbr_event_t  want;

  // mostly short gaps, now and then a long one
  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if (quiet || r < 55) return 0;
    if (r < 90) return $urandom_range(1, 3);
    return $urandom_range(8, 30);
  endfunction

  // apply one accepted word to the neighbor table, queue the results it causes
  function automatic void track_word(hello_word_t w);
    nbr_event_t  r[$];
    bit          removed;
    logic [31:0] silence;
    logic [31:0] since_flood;
    removed = 1'b0;
    if (!w.mode) begin
      if (w.mask != iface_mask[w.port]) begin
        // mask mismatch: dropped, table untouched
        r.push_back('{EV_MASK_DROP, w.port, w.rid, w.addr, 1'b0});
      end else if (nbr_rid[w.port] != 0 && nbr_rid[w.port] == w.rid) begin
        nbr_addr[w.port] = w.addr;
        nbr_seen[w.port] = w.now;
        r.push_back('{EV_REFRESH, w.port, w.rid, w.addr, 1'b0});
      end else begin
        // a zero rid never matches and leaves the slot empty
        nbr_rid[w.port]  = w.rid;
        nbr_addr[w.port] = w.addr;
        nbr_seen[w.port] = w.now;
        r.push_back('{EV_NEW_NBR, w.port, w.rid, w.addr, 1'b0});
      end
    end else begin
      r.push_back('{EV_SEND_HELLO, '0, '0, '0, 1'b0});
      for (int i = 0; i < PORTS; i++) begin
        silence = w.now - nbr_seen[i];
        if (nbr_rid[i] != 0 && silence > {16'd0, dead_limit}) begin
          r.push_back('{EV_TIMEOUT, i[PORT_W-1:0], nbr_rid[i], nbr_addr[i], 1'b0});
          nbr_rid[i] = '0;
          removed = 1'b1;
        end
      end
      since_flood = w.now - flood_stamp;
      // at most one flood per tick
      if (removed || since_flood >= {16'd0, lsu_period}) begin
        r.push_back('{EV_FLOOD_ALL, '0, '0, '0, 1'b0});
        flood_stamp = w.now;
      end
    end
    r[r.size()-1].last = 1'b1;
    foreach (r[k]) expected_events.push_back(r[k]);
  endfunction

  function automatic void check_field(string what, logic [31:0] exp_v, logic [31:0] act_v);
    if (act_v !== exp_v) begin
      $display("%0t: %s expected %0h actual %0h", $time, what, exp_v, act_v);
      mismatches++;
    end
  endfunction

  // driver: holds one word on the input port until it is taken
  always @(posedge clk) begin
    if (!rst_n) begin
      in_valid <= 1'b0;
    end else begin
      if (in_valid && in_ready) begin
        track_word(cur_word);
        busy = 1'b0;
        gap_left = pick_gap();
      end
      if (!busy) begin
        if (gap_left > 0) begin
          gap_left--;
        end else if (pending_words.size() > 0) begin
          cur_word = pending_words.pop_front();
          busy = 1'b1;
        end
      end
      in_valid       <= busy;
      in_mode        <= cur_word.mode;
      in_port_index  <= cur_word.port;
      in_sender_rid  <= cur_word.rid;
      in_sender_addr <= cur_word.addr;
      in_sender_mask <= cur_word.mask;
      in_now_seconds <= cur_word.now;
    end
  end

  // monitor: compares each result word with the oldest expectation, stalls at random
  always @(posedge clk) begin
    if (rst_n && out_valid && out_ready) begin
      if (expected_events.size() == 0) begin
        $display("%0t: unexpected result word, expected none actual event %0h port %0h",
                 $time, out_event_res, out_port_out);
        mismatches++;
      end else begin
        want = expected_events.pop_front();
        check_field("event", 32'(want.ev), 32'(out_event_res));
        check_field("port", 32'(want.port), 32'(out_port_out));
        check_field("neighbor rid", want.rid, out_neighbor_rid);
        check_field("neighbor addr", want.addr, out_neighbor_addr);
        check_field("last", 32'(want.last), 32'(out_last));
      end
    end
    if (stall_left > 0) begin
      stall_left--;
    end else if (!quiet && $urandom_range(0, 3) == 0) begin
      stall_left = pick_gap();
    end
    out_ready <= (stall_left == 0);
  end

  // watchdog
  always @(posedge clk) begin
    cycles++;
    if (cycles > MAX_CYCLES) begin
      $display("Mismatches found");
      $finish;
    end
  end

  // one register write, mirrored into the predictor once it is taken
  task automatic write_cfg(cfg_idx_t idx, logic [31:0] value);
    @(posedge clk);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= value;
    do @(posedge clk); while (!cfg_ready);
    case (idx)
      CFG_MASK0: iface_mask[0] = value;
      CFG_MASK1: iface_mask[1] = value;
      CFG_MASK2: iface_mask[2] = value;
      CFG_MASK3: iface_mask[3] = value;
      CFG_DEAD:  dead_limit = value[15:0];
      CFG_LSU:   lsu_period = value[15:0];
      default: ;
    endcase
    cfg_valid <= 1'b0;
  endtask

  task automatic set_config(logic [31:0] m0, logic [31:0] m1, logic [31:0] m2,
                            logic [31:0] m3, logic [15:0] dead, logic [15:0] lsu);
    write_cfg(CFG_MASK0, m0);
    write_cfg(CFG_MASK1, m1);
    write_cfg(CFG_MASK2, m2);
    write_cfg(CFG_MASK3, m3);
    write_cfg(CFG_DEAD, {16'd0, dead});
    write_cfg(CFG_LSU, {16'd0, lsu});
  endtask

  task automatic send(logic mode, logic [PORT_W-1:0] port, logic [31:0] rid,
                      logic [31:0] addr, logic [31:0] mask, logic [31:0] now);
    pending_words.push_back('{mode, port, rid, addr, mask, now});
  endtask

  // wait until every word is sent and every result is back, then let the
  // sequencer settle
  task automatic drain();
    while (pending_words.size() > 0 || busy || expected_events.size() > 0)
      @(posedge clk);
    repeat (12) @(posedge clk);
  endtask

  // mostly well-formed hellos from a small set of neighbors per interface, with
  // time moving around the dead limit; some bad masks, odd rids and time jumps
  task automatic gen_traffic(int count);
    logic [31:0] rid_pool[PORTS][2];
    hello_word_t w;
    int          r;
    int unsigned d;
    d = 32'(dead_limit);
    foreach (rid_pool[p, j]) rid_pool[p][j] = $urandom_range(1, 32'hFFFF_FFFF);
    repeat (count) begin
      w.mode = ($urandom_range(0, 99) < 22);
      w.port = PORT_W'($urandom_range(0, PORTS - 1));
      w.addr = $urandom;
      r = $urandom_range(0, 99);
      if (r < 70) w.rid = rid_pool[w.port][r % 2];
      else if (r < 92) w.rid = $urandom;
      else w.rid = '0;
      r = $urandom_range(0, 99);
      if (r < 88) w.mask = iface_mask[w.port];
      else if (r < 94) w.mask = ~iface_mask[w.port];
      else w.mask = $urandom;
      r = $urandom_range(0, 99);
      if (r < 65) sim_clock = sim_clock + $urandom_range(0, d / 2 + 1);
      else if (r < 95) sim_clock = sim_clock + $urandom_range(d / 2, d * 2 + 2);
      else sim_clock = $urandom;
      w.now = sim_clock;
      pending_words.push_back(w);
    end
  endtask

  initial begin
    // predictor starts from the reset state
    foreach (iface_mask[i]) begin
      iface_mask[i] = '0;
      nbr_rid[i]    = '0;
      nbr_addr[i]   = '0;
      nbr_seen[i]   = '0;
    end
    dead_limit  = 16'd15;
    lsu_period  = 16'd30;
    flood_stamp = '0;

    repeat (6) @(posedge clk);
    rst_n <= 1'b1;

    // directed: every event kind, rid zero, all-ones fields, time wrap
    set_config(32'hFFFF_FF00, 32'hFFFF_0000, 32'h0000_0000, 32'hFFFF_FFFF, 16'd15, 16'd30);
    send(1'b0, 2'd0, 32'h0A00_0001, 32'h0A00_0002, 32'hFFFF_FF00, 32'd100);  // new neighbor
    send(1'b0, 2'd0, 32'h0A00_0001, 32'h0A00_0003, 32'hFFFF_FF00, 32'd105);  // refresh
    send(1'b0, 2'd1, 32'h0000_0005, 32'h0B00_0009, 32'hFFFF_FF00, 32'd106);  // mask drop
    send(1'b0, 2'd1, 32'h0B00_0001, 32'h0B00_0002, 32'hFFFF_0000, 32'd106);
    send(1'b0, 2'd2, 32'h0000_0000, 32'h0C00_0001, 32'h0000_0000, 32'd107);  // zero rid
    send(1'b0, 2'd2, 32'h0000_0000, 32'h0C00_0002, 32'h0000_0000, 32'd107);  // still new
    send(1'b0, 2'd3, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'd108);
    send(1'b0, 2'd3, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'h0000_0000, 32'd108);  // mask drop
    send(1'b1, 2'd0, 32'h0, 32'h0, 32'h0, 32'd110);                          // periodic flood
    send(1'b1, 2'd0, 32'h0, 32'h0, 32'h0, 32'd115);                          // hellos only
    send(1'b1, 2'd0, 32'h0, 32'h0, 32'h0, 32'd123);                          // two time out
    send(1'b1, 2'd0, 32'h0, 32'h0, 32'h0, 32'd124);                          // silence just over
    send(1'b0, 2'd0, 32'h0A00_0001, 32'h0A00_0004, 32'hFFFF_FF00, 32'd200);
    send(1'b0, 2'd0, 32'h0C00_0001, 32'h0A00_0005, 32'hFFFF_FF00, 32'd201);  // replaced
    send(1'b0, 2'd1, 32'h0B00_0001, 32'h0B00_0003, 32'hFFFF_0000, 32'hFFFF_FFF0);
    send(1'b1, 2'd2, 32'h0, 32'h0, 32'h0, 32'h0000_0005);                    // wrapped time
    send(1'b0, 2'd2, 32'h0000_0000, 32'h0000_0000, 32'hFFFF_FFFF, 32'd6);    // drop, rid zero
    send(1'b1, 2'd3, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
    send(1'b0, 2'd3, 32'h0000_0001, 32'h0000_0000, 32'hFFFF_FFFF, 32'h0);
    drain();

    // limits of one, no idling at all
    quiet = 1'b1;
    set_config($urandom, $urandom, 32'hFFFF_FFFF, 32'h0, 16'd1, 16'd1);
    gen_traffic(25);
    drain();
    quiet = 1'b0;

    // largest limits
    set_config(32'h0, 32'hFFFF_FFFF, 32'h0, 32'hFFFF_FFFF, 16'hFFFF, 16'hFFFF);
    gen_traffic(25);
    drain();

    // mid-range, with a full stop halfway so the sender waits for every result
    set_config($urandom, $urandom, $urandom, $urandom, 16'd20, 16'd45);
    gen_traffic(13);
    drain();
    gen_traffic(13);
    drain();

    // short dead limit, periodic flood effectively off
    set_config(32'hFFFF_FF00, $urandom, 32'hFFFF_FFFC, $urandom, 16'd3, 16'hFFFF);
    gen_traffic(25);
    drain();

    if (mismatches == 0 && expected_events.size() == 0) begin
      $display("No mismatches found");
    end else begin
      $display("Mismatches found");
    end
    $finish;
  end

endmodule
